// File: rtl/core/integer_to_radix_digits_defines.svh
// ----------------------------------------------------------------------------
// integer_to_radix_digits assertion macros
// shared concurrent assertion forms, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ITD_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_to_radix_digits: assertion failed");
// next-cycle implication
`define ITD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_to_radix_digits: assertion failed");
`else
`define ITD_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ITD_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/itd_pkg.sv
// ----------------------------------------------------------------------------
// itd_pkg
// constants, types and codes shared by the radix digit converter
// ----------------------------------------------------------------------------
package itd_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int MAX_BASE       = 16;
    localparam int MIN_BASE       = 2;
    localparam int ALPHABET_CHARS = 16;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = $clog2(ALPHABET_CHARS);
    localparam int BASE_W         = 5;
    localparam int IDX_W          = $clog2(VALUE_BITS);
    localparam int CNT_W          = $clog2(VALUE_BITS + 1);
    localparam int ALPHABET_W     = ALPHABET_CHARS * CHAR_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TOP   = 8'd126;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_W-1:0]    remainder;
    } div_result_t;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_result_t;

endpackage

// File: rtl/core/itd_divider.sv
// ----------------------------------------------------------------------------
// itd_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module itd_divider
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [itd_pkg::VALUE_BITS-1:0]      dividend,
    input  logic [itd_pkg::BASE_W-1:0]          divisor,
    output itd_pkg::div_result_t                result
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [itd_pkg::IDX_W-1:0]         cnt_reg, cnt_next;
    logic [itd_pkg::VALUE_BITS-1:0]    q_reg, q_next;
    logic [itd_pkg::DIGIT_W-1:0]       r_reg, r_next;
    logic [itd_pkg::DIGIT_W:0]         trial;
    logic [itd_pkg::DIGIT_W:0]         diff;
    logic                              ge;

    // trial subtract of the shifted partial remainder
    assign trial = {r_reg, q_reg[itd_pkg::VALUE_BITS-1]};
    assign ge    = (trial >= divisor);
    assign diff  = trial - divisor;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[itd_pkg::VALUE_BITS-2:0], ge};
            r_next   = ge ? diff[itd_pkg::DIGIT_W-1:0] : trial[itd_pkg::DIGIT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == itd_pkg::IDX_W'(itd_pkg::VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = q_reg;
    assign result.remainder = r_reg;

endmodule

// File: rtl/core/itd_alpha_check.sv
// ----------------------------------------------------------------------------
// itd_alpha_check
// walks the alphabet one character per cycle checking range and uniqueness
// ----------------------------------------------------------------------------
module itd_alpha_check
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [itd_pkg::BASE_W-1:0]          base_size,
    input  logic [itd_pkg::ALPHABET_W-1:0]      alphabet,
    output itd_pkg::chk_result_t                result
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic                              ok_reg, ok_next;
    logic                              bad_reg, bad_next;
    logic [itd_pkg::DIGIT_W-1:0]       idx_reg, idx_next;
    logic [itd_pkg::CHAR_W-1:0]        cur_char;
    logic                              dup;
    logic                              bad_now;
    logic                              size_ok;
    logic                              at_end;

    assign size_ok  = (base_size >= itd_pkg::BASE_W'(itd_pkg::MIN_BASE))
                   && (base_size <= itd_pkg::BASE_W'(itd_pkg::MAX_BASE));
    assign cur_char = alphabet[{idx_reg, 3'b000} +: itd_pkg::CHAR_W];
    assign at_end   = ({1'b0, idx_reg} == (base_size - 1'b1));

    // compare against every later character inside the radix
    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < itd_pkg::ALPHABET_CHARS; j++)
        begin
            if ((itd_pkg::BASE_W'(j) > {1'b0, idx_reg})
                && (itd_pkg::BASE_W'(j) < base_size)
                && (alphabet[j*itd_pkg::CHAR_W +: itd_pkg::CHAR_W] == cur_char))
            begin
                dup = 1'b1;
            end
        end
    end

    assign bad_now = dup
                  || (cur_char <= itd_pkg::CHAR_SPACE)
                  || (cur_char > itd_pkg::CHAR_TOP)
                  || (cur_char == itd_pkg::CHAR_PLUS)
                  || (cur_char == itd_pkg::CHAR_MINUS);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ok_next   = ok_reg;
        bad_next  = bad_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            idx_next = '0;
            bad_next = 1'b0;
            if (size_ok)
            begin
                busy_next = 1'b1;
            end
            else
            begin
                done_next = 1'b1;
                ok_next   = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            bad_next = bad_reg | bad_now;
            idx_next = idx_reg + 1'b1;
            if (at_end)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = !(bad_reg | bad_now);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            bad_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
            bad_reg  <= bad_next;
            idx_reg  <= idx_next;
        end
    end

    assign result.done = done_reg;
    assign result.ok   = ok_reg;

endmodule

// File: rtl/core/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to text in a configured radix
// sequence: alphabet check (skipped for zero), then one division per digit in
//   the shared bit-serial divider, then one character per cycle while the receiver is ready
// flow: one value at a time, the next value is taken only back in idle
// reset: rst_n async low, idle, control and configuration registers zero, no transfer pending
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_defines.svh"

module integer_to_radix_digits
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [itd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [itd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [itd_pkg::VALUE_BITS-1:0] value,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [itd_pkg::CHAR_W-1:0]          character,
    output logic                                last
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ZERO   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_DIVIDE = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    // configuration registers
    logic [itd_pkg::BASE_W-1:0]          base_size_reg;
    logic [itd_pkg::CFG_DATA_W-1:0]      alphabet_low_reg;
    logic [itd_pkg::CFG_DATA_W-1:0]      alphabet_high_reg;
    logic [itd_pkg::ALPHABET_W-1:0]      alphabet;

    // sequencer and datapath
    logic [2:0]                          state_reg, state_next;
    logic                                neg_reg, neg_next;
    logic [itd_pkg::VALUE_BITS-1:0]      mag_reg, mag_next;
    logic [itd_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [itd_pkg::DIGIT_W-1:0]         digit_reg [itd_pkg::VALUE_BITS];
    logic                                push;
    logic [itd_pkg::CNT_W-1:0]           count_dec;
    logic [itd_pkg::DIGIT_W-1:0]         top_digit;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic [itd_pkg::CHAR_W-1:0]          character_reg, character_next;
    logic                                last_reg, last_next;
    logic                                out_free;
    logic                                load;

    logic                                in_fire;
    logic [itd_pkg::VALUE_BITS-1:0]      in_mag;

    logic                                div_start;
    logic [itd_pkg::VALUE_BITS-1:0]      div_dividend;
    itd_pkg::div_result_t                div_res;
    logic                                chk_start;
    itd_pkg::chk_result_t                chk_res;

    // ------------------------------------------------------------------
    // configuration port, never stalls; an unknown index is dropped
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg     <= '0;
            alphabet_low_reg  <= '0;
            alphabet_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                itd_pkg::REG_BASE_SIZE:
                    base_size_reg <= cfg_data[itd_pkg::BASE_W-1:0];
                itd_pkg::REG_ALPHABET_LOW:
                    alphabet_low_reg <= cfg_data;
                itd_pkg::REG_ALPHABET_HIGH:
                    alphabet_high_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign alphabet = {alphabet_high_reg, alphabet_low_reg};

    // ------------------------------------------------------------------
    // input side: magnitude in unsigned form, most negative value wraps
    // to its own unsigned magnitude
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_mag   = value[itd_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;

    // output slot can take a character this cycle
    assign out_free = !out_valid_reg || out_ready;

    // digits come out least significant first, so they stack up and are
    // read back from the top
    assign count_dec = count_reg - 1'b1;
    assign top_digit = digit_reg[count_dec[itd_pkg::IDX_W-1:0]];

    // first division runs on the stored magnitude, later ones on the
    // quotient just produced
    assign div_dividend = (state_reg == ST_DIVIDE) ? div_res.quotient : mag_reg;
    assign chk_start    = in_fire && (value != '0);

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        count_next     = count_reg;
        push           = 1'b0;
        div_start      = 1'b0;
        load           = 1'b0;
        character_next = character_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next   = value[itd_pkg::VALUE_BITS-1];
                    mag_next   = in_mag;
                    count_next = '0;
                    state_next = (value == '0) ? ST_ZERO : ST_CHECK;
                end
            end
            ST_ZERO:
            begin
                // zero always gives alphabet character 0
                if (out_free)
                begin
                    load           = 1'b1;
                    character_next = alphabet_low_reg[itd_pkg::CHAR_W-1:0];
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (chk_res.done)
                begin
                    if (!chk_res.ok)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (neg_reg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    character_next = itd_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    div_start      = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    push       = 1'b1;
                    count_next = count_reg + 1'b1;
                    mag_next   = div_res.quotient;
                    if (div_res.quotient == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    character_next = alphabet[{top_digit, 3'b000} +: itd_pkg::CHAR_W];
                    last_next      = (count_reg == itd_pkg::CNT_W'(1));
                    count_next     = count_dec;
                    if (count_reg == itd_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        character_reg <= character_next;
        last_reg      <= last_next;
        if (push)
        begin
            digit_reg[count_reg[itd_pkg::IDX_W-1:0]] <= div_res.remainder;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    itd_alpha_check u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (chk_start),
        .base_size (base_size_reg),
        .alphabet  (alphabet),
        .result    (chk_res)
    );

    itd_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (base_size_reg),
        .result   (div_res)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // an accepted value always takes the sequencer out of idle in the next cycle
    `ITD_ASSERT_NEXT(a_leave_idle, clk, rst_n, in_fire, state_reg != ST_IDLE)
    // the digit stack never grows past one digit per value bit
    `ITD_ASSERT_IMPLIES(a_stack_bound, clk, rst_n, 1'b1, count_reg <= itd_pkg::CNT_W'(itd_pkg::VALUE_BITS))
    // emitting from an empty stack would underflow
    `ITD_ASSERT_IMPLIES(a_emit_nonempty, clk, rst_n, state_reg == ST_EMIT, count_reg != '0)
    // the divider only finishes while the sequencer waits for it
    `ITD_ASSERT_IMPLIES(a_div_owner, clk, rst_n, div_res.done, state_reg == ST_DIVIDE)

endmodule

// File: tb/integer_to_radix_digits_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_checker
// follows register writes, works out the text of every accepted value and
// compares each output transfer with the oldest character still owed
// ----------------------------------------------------------------------------
module integer_to_radix_digits_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [itd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [itd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [itd_pkg::VALUE_BITS-1:0] value,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [itd_pkg::CHAR_W-1:0]            character,
    input  logic                                  last,
    output int unsigned                           mismatches,
    output int unsigned                           chars_due
);
    import itd_pkg::*;

    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } text_char_t;

    text_char_t            owed_text [$];
    logic [BASE_W-1:0]     radix;
    logic [ALPHABET_W-1:0] alphabet;
    int unsigned           error_count = 0;

    function automatic logic [CHAR_W-1:0] digit_symbol(input int unsigned idx);
        return alphabet[idx*CHAR_W +: CHAR_W];
    endfunction

    function automatic bit alphabet_usable();
        logic [CHAR_W-1:0] c;
        if (radix < MIN_BASE || radix > MAX_BASE)
            return 1'b0;
        for (int i = 0; i < radix; i++)
        begin
            c = digit_symbol(i);
            if (c <= CHAR_SPACE || c > CHAR_TOP || c == CHAR_PLUS || c == CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < radix; j++)
                if (digit_symbol(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // text of one value, most significant digit first
    task automatic queue_text(input logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [DIGIT_W-1:0]    digits [0:VALUE_BITS-1];
        int                    nd;
        text_char_t            tc;
        if (v == 0)
        begin
            // zero ignores the alphabet check
            tc.ch      = digit_symbol(0);
            tc.is_last = 1'b1;
            owed_text.push_back(tc);
            return;
        end
        if (!alphabet_usable())
            return;
        if (v < 0)
        begin
            tc.ch      = CHAR_MINUS;
            tc.is_last = 1'b0;
            owed_text.push_back(tc);
            mag = ~v + 1'b1;
        end
        else
            mag = v;
        nd = 0;
        while (mag != 0)
        begin
            digits[nd] = DIGIT_W'(mag % radix);
            mag        = mag / radix;
            nd++;
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            tc.ch      = digit_symbol(digits[k]);
            tc.is_last = (k == 0);
            owed_text.push_back(tc);
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        // keep the log short when the block is badly off
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        text_char_t want;
        if (!rst_n)
        begin
            radix    = '0;
            alphabet = '0;
            owed_text.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_BASE_SIZE:     radix = cfg_data[BASE_W-1:0];
                    REG_ALPHABET_LOW:  alphabet[CFG_DATA_W-1:0] = cfg_data;
                    REG_ALPHABET_HIGH: alphabet[ALPHABET_W-1:CFG_DATA_W] = cfg_data;
                    default: ;
                endcase
            if (in_valid && in_ready)
                queue_text(value);
            if (out_valid && out_ready)
            begin
                if (owed_text.size() == 0)
                    report_mismatch($sformatf("character %h last %b with none owed",
                                              character, last));
                else
                begin
                    want = owed_text.pop_front();
                    if (character !== want.ch)
                        report_mismatch($sformatf("character %h, wanted %h",
                                                  character, want.ch));
                    if (last !== want.is_last)
                        report_mismatch($sformatf("last %b, wanted %b on character %h",
                                                  last, want.is_last, want.ch));
                end
            end
        end
        mismatches <= error_count;
        chars_due  <= owed_text.size();
    end

endmodule

// File: tb/integer_to_radix_digits_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_tb
// drives register settings and values into the radix converter under random
// sender and receiver idling; the checker beside it predicts every character
// ----------------------------------------------------------------------------
module integer_to_radix_digits_tb;
    import itd_pkg::*;

    // time for the slowest value to finish, allowed before a write
    localparam int SETTLE_CYCLES     = 1200;
    localparam int RANDOM_SETTINGS   = 12;
    localparam int ITEMS_PER_SETTING = 32;
    // index past the register list, the write must be dropped
    localparam logic [CFG_IDX_W-1:0]  REG_UNUSED = 2'd3;
    // character 0 in the lowest byte
    localparam logic [ALPHABET_W-1:0] HEX_DIGITS = "FEDCBA9876543210";

    typedef enum int {
        FLAW_NONE,
        FLAW_REPEAT,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_LOW,
        FLAW_HIGH
    } alphabet_flaw_e;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic signed [VALUE_BITS-1:0] value     = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [CHAR_W-1:0]            character;
    logic                         last;

    int unsigned mismatches;
    int unsigned chars_due;
    int unsigned send_idle_pct = 24;
    int unsigned recv_idle_pct = 69;
    // in_valid is being held high across transfers
    bit          value_held    = 1'b0;

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    integer_to_radix_digits uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    integer_to_radix_digits_checker text_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last),
        .mismatches (mismatches),
        .chars_due  (chars_due)
    );

    // receiver stalls at random, one decision per cycle
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // one register write, with valid dropped again before the next
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // offer one value; valid either stays up for the next one or drops for a gap
    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        value      <= v;
        in_valid   <= 1'b1;
        value_held  = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transfer taken at this edge
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid   <= 1'b0;
            value_held  = 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic release_input();
        if (value_held)
        begin
            in_valid   <= 1'b0;
            value_held  = 1'b0;
        end
    endtask

    // wait for every owed character, then for a value that gives none
    task automatic wait_idle();
        release_input();
        // let the last transfer show in chars_due first
        @(posedge clk);
        while (chars_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // new radix and alphabet; upper bits of the radix word are noise
    task automatic apply_setting(input logic [BASE_W-1:0] radix,
                                 input logic [ALPHABET_W-1:0] alpha);
        wait_idle();
        write_reg(REG_BASE_SIZE, {$urandom, 27'($urandom), radix});
        write_reg(REG_ALPHABET_LOW, alpha[CFG_DATA_W-1:0]);
        write_reg(REG_ALPHABET_HIGH, alpha[ALPHABET_W-1:CFG_DATA_W]);
        write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    // distinct legal characters in the first n places, random bytes above,
    // then at most one defect among the first n
    function automatic logic [ALPHABET_W-1:0] make_alphabet(input int unsigned n,
                                                            input alphabet_flaw_e flaw);
        logic [CHAR_W-1:0]     pool [0:91];
        logic [CHAR_W-1:0]     tmp;
        logic [ALPHABET_W-1:0] alpha;
        int unsigned           cnt;
        int unsigned           j;
        int unsigned           p;
        int unsigned           q;
        cnt = 0;
        for (int c = CHAR_SPACE + 1; c <= CHAR_TOP; c++)
            if (CHAR_W'(c) != CHAR_PLUS && CHAR_W'(c) != CHAR_MINUS)
            begin
                pool[cnt] = CHAR_W'(c);
                cnt++;
            end
        for (int i = 0; i < ALPHABET_CHARS; i++)
        begin
            j       = $urandom_range(91, i);
            tmp     = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
            if (i < n)
                alpha[i*CHAR_W +: CHAR_W] = pool[i];
            else
                alpha[i*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(255));
        end
        if (n >= 2 && n <= ALPHABET_CHARS)
        begin
            p = $urandom_range(n - 1);
            q = (p + 1 + $urandom_range(n - 2)) % n;
            case (flaw)
                FLAW_REPEAT: alpha[p*CHAR_W +: CHAR_W] = alpha[q*CHAR_W +: CHAR_W];
                FLAW_PLUS:   alpha[p*CHAR_W +: CHAR_W] = CHAR_PLUS;
                FLAW_MINUS:  alpha[p*CHAR_W +: CHAR_W] = CHAR_MINUS;
                FLAW_LOW:    alpha[p*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(CHAR_SPACE));
                FLAW_HIGH:   alpha[p*CHAR_W +: CHAR_W] =
                                 CHAR_W'($urandom_range(255, CHAR_TOP + 1));
                default: ;
            endcase
        end
        return alpha;
    endfunction

    // mostly full-range values, with zero, the ends of the range and short
    // texts mixed in
    function automatic logic signed [VALUE_BITS-1:0] pick_value(input int unsigned radix);
        logic signed [VALUE_BITS-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1:
                case ($urandom_range(3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = -1;
                    default: v = 1;
                endcase
            2, 3:
            begin
                v = $urandom_range(radix * radix * radix + 1);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // hard stop well beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d characters still owed", chars_due);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [BASE_W-1:0] radix;
        alphabet_flaw_e    flaw;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // straight out of reset: radix 0, alphabet all zero bytes
        send_value(0);
        send_value(7);

        // hex, signs and the ends of the range
        apply_setting(5'd16, HEX_DIGITS);
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(15);
        send_value(16);
        send_value(-16);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);

        // binary with junk bytes above the radix; most negative gives the longest text
        apply_setting(5'd2, {{14{8'hFF}}, "10"});
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(-1);
        send_value(2);

        // radix beyond the alphabet: zero still gives character 0
        apply_setting(5'd31, HEX_DIGITS);
        send_value(0);
        send_value(12345);
        apply_setting(5'd1, HEX_DIGITS);
        send_value(-5);
        apply_setting(5'd0, HEX_DIGITS);
        send_value(9);

        // one of each alphabet defect
        for (int f = FLAW_REPEAT; f <= FLAW_HIGH; f++)
        begin
            apply_setting(5'd10, make_alphabet(10, alphabet_flaw_e'(f)));
            send_value(-(1 + $urandom_range(1000)));
        end
        send_value(0);

        // --- random part ---
        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            // idling swaps sides after a third, stops after two thirds
            if (s == RANDOM_SETTINGS / 3)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 24;
            end
            else if (s == 2 * RANDOM_SETTINGS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            radix = BASE_W'($urandom_range(MAX_BASE, MIN_BASE));
            flaw  = FLAW_NONE;
            case ($urandom_range(7))
                0: radix = $urandom_range(1) ? BASE_W'($urandom_range(1))
                                             : BASE_W'($urandom_range(31, MAX_BASE + 1));
                1: flaw = alphabet_flaw_e'($urandom_range(FLAW_HIGH, FLAW_REPEAT));
                default: ;
            endcase
            apply_setting(radix, make_alphabet(radix, flaw));
            for (int k = 0; k < ITEMS_PER_SETTING; k++)
                send_value(pick_value(radix));
        end

        // drain and give the verdict
        wait_idle();
        if (mismatches == 0 && chars_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: integer_to_radix_digits.f
+incdir+rtl/core
rtl/core/itd_pkg.sv
rtl/core/itd_divider.sv
rtl/core/itd_alpha_check.sv
rtl/core/integer_to_radix_digits.sv
tb/integer_to_radix_digits_checker.sv
tb/integer_to_radix_digits_tb.sv
